### src/pslg_segment_validator_macros.svh
// Assertion macros for the segment validator checker.
`ifndef PSLG_SEGMENT_VALIDATOR_MACROS_SVH
`define PSLG_SEGMENT_VALIDATOR_MACROS_SVH

// Checked outside reset.
`define PSLG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PSLG_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/pslg_pkg.sv
// ----------------------------------------------------------------------------
// pslg_pkg
// Shared types and codes of the segment validator.
// ----------------------------------------------------------------------------
`default_nettype none

package pslg_pkg;

  localparam int IDX_BITS = 12;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_POINT   = 2'd1,
    OP_SEGMENT = 2'd2,
    OP_CHECK   = 2'd3
  } opcode_t;

  localparam logic [1:0] VERDICT_VALID    = 2'd0;
  localparam logic [1:0] VERDICT_INVALID  = 2'd1;
  localparam logic [1:0] VERDICT_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    SGN_ZERO = 2'd0,
    SGN_POS  = 2'd1,
    SGN_NEG  = 2'd2
  } sign_t;

  typedef struct packed {
    logic  done;
    sign_t sign;
  } orient_res_t;

endpackage

`default_nettype wire

### src/pslg_orient.sv
// ----------------------------------------------------------------------------
// pslg_orient
// Exact sign of (p1 - p0) x (p2 - p0) using one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module pslg_orient #(
  parameter int CW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [CW-1:0] x0,
  input  wire logic signed [CW-1:0] y0,
  input  wire logic signed [CW-1:0] x1,
  input  wire logic signed [CW-1:0] y1,
  input  wire logic signed [CW-1:0] x2,
  input  wire logic signed [CW-1:0] y2,
  output pslg_pkg::orient_res_t     res
);
  import pslg_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  typedef enum logic [1:0] {O_IDLE, O_MUL1, O_MUL2, O_CMP} ostate_t;

  ostate_t state;
  logic signed [DW-1:0] dx1, dy1, dx2, dy2;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod, p1, p2;

  assign mul_a = (state == O_MUL1) ? dx1 : dy1;
  assign mul_b = (state == O_MUL1) ? dy2 : dx2;
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= O_IDLE;
      res.done <= 1'b0;
      res.sign <= SGN_ZERO;
    end else begin
      res.done <= 1'b0;
      unique case (state)
        O_IDLE: begin
          if (start) begin
            dx1   <= DW'(x1) - DW'(x0);
            dy1   <= DW'(y1) - DW'(y0);
            dx2   <= DW'(x2) - DW'(x0);
            dy2   <= DW'(y2) - DW'(y0);
            state <= O_MUL1;
          end
        end
        O_MUL1: begin
          p1    <= prod;
          state <= O_MUL2;
        end
        O_MUL2: begin
          p2    <= prod;
          state <= O_CMP;
        end
        O_CMP: begin
          res.done <= 1'b1;
          if (p1 > p2) begin
            res.sign <= SGN_POS;
          end else if (p1 < p2) begin
            res.sign <= SGN_NEG;
          end else begin
            res.sign <= SGN_ZERO;
          end
          state <= O_IDLE;
        end
        default: state <= O_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/pslg_segment_validator.sv
// ----------------------------------------------------------------------------
// pslg_segment_validator
// Point and segment stores with a pairwise straight-line graph checker.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers when start is high and busy is low. Clear, load
//   point and load segment give no result and leave busy low, so loads can
//   stream one per cycle.
//   Run check raises busy and, when finished, pulses done for one cycle with
//   verdict (0 valid, 1 invalid, 2 overflow). After an overflow the verdict
//   comes on the next cycle without raising busy.
//   A check with P points and S segments loaded first clears the P
//   degrees, then checks the 2S segment end indices, then makes a pass
//   per segment and four orientation tests per segment pair on the shared
//   multiplier, and last checks the P degrees. The pair loop dominates.
//   An invalid graph ends the check early at the first failure found.
//   The result cannot be stalled; done is a one-cycle strobe.
//   Reset empties both stores, clears the overflow flag and returns idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pslg_segment_validator #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_SEGMENTS = 1024,
  parameter int COORD_BITS   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] coord_x,
  input  wire logic [31:0] coord_y,
  input  wire logic [pslg_pkg::IDX_BITS-1:0] end_a,
  input  wire logic [pslg_pkg::IDX_BITS-1:0] end_b,
  output logic             done,
  output logic [1:0]       verdict
);
  import pslg_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int PA   = $clog2(MAX_POINTS);
  localparam int PC   = $clog2(MAX_POINTS + 1);
  localparam int SA   = $clog2(MAX_SEGMENTS);
  localparam int SC   = $clog2(MAX_SEGMENTS + 1);
  localparam int CMPW = (PC > IDX_BITS) ? PC : IDX_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_IDX_RD, S_IDX_CHK, S_I_RD, S_I_SEG, S_I_PA, S_I_PB,
    S_DA_RD, S_DA_WR, S_DB_RD, S_DB_WR, S_J_RD, S_J_SEG, S_J_PC, S_J_PD,
    S_OR, S_OR_W, S_DEC, S_FIN_RD, S_FIN_CHK
  } state_t;

  state_t state;

  logic signed [CW-1:0] px_mem [MAX_POINTS];
  logic signed [CW-1:0] py_mem [MAX_POINTS];
  logic [IDX_BITS-1:0]  sa_mem [MAX_SEGMENTS];
  logic [IDX_BITS-1:0]  sb_mem [MAX_SEGMENTS];
  logic [1:0]           deg_mem [MAX_POINTS];

  logic signed [CW-1:0] px_q, py_q;
  logic [IDX_BITS-1:0]  sa_q, sb_q;
  logic [1:0]           deg_q;

  logic [PC-1:0] pl;
  logic [SC-1:0] sl;
  logic          ovf;

  logic [SC-1:0] i, j;
  logic [PC-1:0] k;
  logic [1:0]    oi;
  sign_t         o [4];

  logic [IDX_BITS-1:0] a_r, b_r, c_r, d_r;
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  logic [PA-1:0] pt_addr, deg_addr;
  logic [SA-1:0] seg_addr;
  logic          deg_we;
  logic [1:0]    deg_wd;
  logic          pt_we, seg_we, accept;

  logic or_start;
  logic signed [CW-1:0] ox0, oy0, ox1, oy1, ox2, oy2;
  orient_res_t or_res;

  logic on0, on1, on2, on3, shares, fail_shared, strict, pair_fail;

  function automatic logic in_box(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy,
                                  logic signed [CW-1:0] sx0, logic signed [CW-1:0] sy0,
                                  logic signed [CW-1:0] sx1, logic signed [CW-1:0] sy1);
    return ((qx >= sx0 && qx <= sx1) || (qx >= sx1 && qx <= sx0)) &&
           ((qy >= sy0 && qy <= sy1) || (qy >= sy1 && qy <= sy0));
  endfunction

  function automatic logic opposite(sign_t s0, sign_t s1);
    return (s0 == SGN_POS && s1 == SGN_NEG) || (s0 == SGN_NEG && s1 == SGN_POS);
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pt_we  = accept && (opcode_t'(opcode) == OP_POINT) && (pl < PC'(MAX_POINTS));
  assign seg_we = accept && (opcode_t'(opcode) == OP_SEGMENT) && (sl < SC'(MAX_SEGMENTS));
  assign or_start = (state == S_OR);

  // store addressing
  always_comb begin
    pt_addr  = '0;
    seg_addr = '0;
    deg_addr = '0;
    deg_we   = 1'b0;
    deg_wd   = '0;
    case (state)
      S_I_SEG:  pt_addr = sa_q[PA-1:0];
      S_I_PA:   pt_addr = b_r[PA-1:0];
      S_J_SEG:  pt_addr = sa_q[PA-1:0];
      S_J_PC:   pt_addr = d_r[PA-1:0];
      default:  pt_addr = '0;
    endcase
    case (state)
      S_IDX_RD, S_I_RD: seg_addr = i[SA-1:0];
      S_J_RD:           seg_addr = j[SA-1:0];
      default:          seg_addr = '0;
    endcase
    case (state)
      S_CLR: begin
        deg_addr = k[PA-1:0];
        deg_we   = (k != pl);
      end
      S_DA_RD, S_DA_WR: begin
        deg_addr = a_r[PA-1:0];
        deg_we   = (state == S_DA_WR);
        deg_wd   = (deg_q == 2'd3) ? 2'd3 : deg_q + 2'd1;
      end
      S_DB_RD, S_DB_WR: begin
        deg_addr = b_r[PA-1:0];
        deg_we   = (state == S_DB_WR);
        deg_wd   = (deg_q == 2'd3) ? 2'd3 : deg_q + 2'd1;
      end
      S_FIN_RD: deg_addr = k[PA-1:0];
      default:  deg_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    px_q <= px_mem[pt_addr];
    py_q <= py_mem[pt_addr];
    if (pt_we) begin
      px_mem[pl[PA-1:0]] <= coord_x[CW-1:0];
      py_mem[pl[PA-1:0]] <= coord_y[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sa_q <= sa_mem[seg_addr];
    sb_q <= sb_mem[seg_addr];
    if (seg_we) begin
      sa_mem[sl[SA-1:0]] <= end_a;
      sb_mem[sl[SA-1:0]] <= end_b;
    end
  end

  always_ff @(posedge clk) begin
    deg_q <= deg_mem[deg_addr];
    if (deg_we) begin
      deg_mem[deg_addr] <= deg_wd;
    end
  end

  // orientation operands: abc, abd, cda, cdb
  always_comb begin
    case (oi)
      2'd0: begin
        ox0 = ax; oy0 = ay; ox1 = bx; oy1 = by; ox2 = cx; oy2 = cy;
      end
      2'd1: begin
        ox0 = ax; oy0 = ay; ox1 = bx; oy1 = by; ox2 = dx; oy2 = dy;
      end
      2'd2: begin
        ox0 = cx; oy0 = cy; ox1 = dx; oy1 = dy; ox2 = ax; oy2 = ay;
      end
      default: begin
        ox0 = cx; oy0 = cy; ox1 = dx; oy1 = dy; ox2 = bx; oy2 = by;
      end
    endcase
  end

  pslg_orient #(.CW(CW)) u_orient (
    .clk   (clk),
    .rst   (rst),
    .start (or_start),
    .x0    (ox0),
    .y0    (oy0),
    .x1    (ox1),
    .y1    (oy1),
    .x2    (ox2),
    .y2    (oy2),
    .res   (or_res)
  );

  // pair decision
  always_comb begin
    on0 = (o[0] == SGN_ZERO) && in_box(cx, cy, ax, ay, bx, by);
    on1 = (o[1] == SGN_ZERO) && in_box(dx, dy, ax, ay, bx, by);
    on2 = (o[2] == SGN_ZERO) && in_box(ax, ay, cx, cy, dx, dy);
    on3 = (o[3] == SGN_ZERO) && in_box(bx, by, cx, cy, dx, dy);
    shares = (ax == cx && ay == cy) || (ax == dx && ay == dy) ||
             (bx == cx && by == cy) || (bx == dx && by == dy);
    fail_shared = (c_r != a_r && c_r != b_r && on0) ||
                  (d_r != a_r && d_r != b_r && on1) ||
                  (a_r != c_r && a_r != d_r && on2) ||
                  (b_r != c_r && b_r != d_r && on3);
    strict = opposite(o[0], o[1]) && opposite(o[2], o[3]);
    pair_fail = shares ? fail_shared : (strict || on0 || on1 || on2 || on3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      verdict <= VERDICT_VALID;
      pl      <= '0;
      sl      <= '0;
      ovf     <= 1'b0;
      i       <= '0;
      j       <= '0;
      k       <= '0;
      oi      <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (opcode_t'(opcode))
              OP_CLEAR: begin
                pl  <= '0;
                sl  <= '0;
                ovf <= 1'b0;
              end
              OP_POINT: begin
                if (pt_we) pl <= pl + 1'b1;
                else ovf <= 1'b1;
              end
              OP_SEGMENT: begin
                if (seg_we) sl <= sl + 1'b1;
                else ovf <= 1'b1;
              end
              OP_CHECK: begin
                if (ovf) begin
                  done    <= 1'b1;
                  verdict <= VERDICT_OVERFLOW;
                end else begin
                  k     <= '0;
                  state <= S_CLR;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CLR: begin
          if (k == pl) begin
            i     <= '0;
            state <= S_IDX_RD;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_IDX_RD: begin
          if (i == sl) begin
            i     <= '0;
            state <= S_I_RD;
          end else begin
            state <= S_IDX_CHK;
          end
        end
        S_IDX_CHK: begin
          if (CMPW'(sa_q) >= CMPW'(pl) || CMPW'(sb_q) >= CMPW'(pl)) begin
            done    <= 1'b1;
            verdict <= VERDICT_INVALID;
            state   <= S_IDLE;
          end else begin
            i     <= i + 1'b1;
            state <= S_IDX_RD;
          end
        end
        S_I_RD: begin
          if (i == sl) begin
            k     <= '0;
            state <= S_FIN_RD;
          end else begin
            state <= S_I_SEG;
          end
        end
        S_I_SEG: begin
          a_r <= sa_q;
          b_r <= sb_q;
          if (sa_q == sb_q) begin
            done    <= 1'b1;
            verdict <= VERDICT_INVALID;
            state   <= S_IDLE;
          end else begin
            state <= S_I_PA;
          end
        end
        S_I_PA: begin
          ax    <= px_q;
          ay    <= py_q;
          state <= S_I_PB;
        end
        S_I_PB: begin
          bx <= px_q;
          by <= py_q;
          if (px_q == ax && py_q == ay) begin
            done    <= 1'b1;
            verdict <= VERDICT_INVALID;
            state   <= S_IDLE;
          end else begin
            state <= S_DA_RD;
          end
        end
        S_DA_RD: state <= S_DA_WR;
        S_DA_WR: state <= S_DB_RD;
        S_DB_RD: state <= S_DB_WR;
        S_DB_WR: begin
          j     <= i + 1'b1;
          state <= S_J_RD;
        end
        S_J_RD: begin
          if (j == sl) begin
            i     <= i + 1'b1;
            state <= S_I_RD;
          end else begin
            state <= S_J_SEG;
          end
        end
        S_J_SEG: begin
          c_r <= sa_q;
          d_r <= sb_q;
          if ((a_r == sa_q && b_r == sb_q) || (a_r == sb_q && b_r == sa_q)) begin
            done    <= 1'b1;
            verdict <= VERDICT_INVALID;
            state   <= S_IDLE;
          end else begin
            state <= S_J_PC;
          end
        end
        S_J_PC: begin
          cx    <= px_q;
          cy    <= py_q;
          state <= S_J_PD;
        end
        S_J_PD: begin
          dx    <= px_q;
          dy    <= py_q;
          oi    <= '0;
          state <= S_OR;
        end
        S_OR: state <= S_OR_W;
        S_OR_W: begin
          if (or_res.done) begin
            o[oi] <= or_res.sign;
            if (oi == 2'd3) begin
              state <= S_DEC;
            end else begin
              oi    <= oi + 2'd1;
              state <= S_OR;
            end
          end
        end
        S_DEC: begin
          if (pair_fail) begin
            done    <= 1'b1;
            verdict <= VERDICT_INVALID;
            state   <= S_IDLE;
          end else begin
            j     <= j + 1'b1;
            state <= S_J_RD;
          end
        end
        S_FIN_RD: begin
          if (k == pl) begin
            done    <= 1'b1;
            verdict <= VERDICT_VALID;
            state   <= S_IDLE;
          end else begin
            state <= S_FIN_CHK;
          end
        end
        S_FIN_CHK: begin
          if (deg_q == 2'd1 || deg_q == 2'd3) begin
            done    <= 1'b1;
            verdict <= VERDICT_INVALID;
            state   <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_FIN_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/pslg_checker.sv
// ----------------------------------------------------------------------------
// pslg_checker
// Port-level checks of the segment validator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pslg_segment_validator_macros.svh"

module pslg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] opcode,
  input wire logic       done,
  input wire logic [1:0] verdict
);
  import pslg_pkg::*;

  `PSLG_ASSERT_ALL(a_reset_idle, rst |=> (!busy && !done), "not idle after reset")
  `PSLG_ASSERT(a_verdict_code, done |-> (verdict != 2'd3), "bad verdict code")
  `PSLG_ASSERT(a_done_idle, done |-> !busy, "result while busy")
  `PSLG_ASSERT(a_load_silent, (start && !busy && opcode != OP_CHECK) |=> (!done && !busy), "load gave a result")
  `PSLG_ASSERT(a_check_start, $rose(busy) |-> !done, "result at check start")

endmodule

bind pslg_segment_validator pslg_checker u_pslg_checker (.*);

`default_nettype wire
